### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (cond), msg)

`endif

### hdl/lpht_pkg.sv
package lpht_pkg;

    localparam int KEY_W     = 31;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int FIELD_W   = 11;
    localparam int DIV_STEPS = 31;
    localparam int DEPTH_DEF = 1024;
    localparam int RESET_CAP = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
    } t_mod_req;

endpackage

### hdl/lpht_mod.sv
module lpht_mod #(
    parameter int CW = lpht_pkg::FIELD_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpht_pkg::t_mod_req i_req,
    input  logic [CW-1:0]      i_divisor,
    output logic               o_done,
    output logic [CW-1:0]      o_rem
);

    logic                      r_busy, n_busy;
    logic [4:0]                r_cnt, n_cnt;
    logic [CW-1:0]             r_rem, n_rem;
    logic [lpht_pkg::KEY_W-1:0] r_dvd, n_dvd;
    logic [CW:0]               s_trial;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        s_trial = {r_rem, r_dvd[lpht_pkg::KEY_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 5'(lpht_pkg::DIV_STEPS);
            n_rem  = '0;
            n_dvd  = i_req.dividend;
        end else if (r_busy) begin
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 5'd1;
                n_dvd = {r_dvd[lpht_pkg::KEY_W-2:0], 1'b0};
                if (s_trial >= {1'b0, i_divisor}) begin
                    n_rem = CW'(s_trial - {1'b0, i_divisor});
                end else begin
                    n_rem = s_trial[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    assign o_done = r_busy && (r_cnt == 5'd0);
    assign o_rem  = r_rem;

endmodule

### hdl/linear_probe_hash_table.sv
// Linear-probing hash table of 31-bit keys held in one slot RAM plus a rehash scratch RAM.
// A search or remove first takes the home slot from a serial remainder unit, then probes
// slots, each probe being one RAM read and one check step. An insert adds a load check.
// An insert that doubles capacity C first scans the C old slots, clears the 2C new slots,
// then re-places every moved key. After reset and after each write of initial_capacity a
// clearing pass over the loaded capacity runs before the first item is accepted.
`include "assert_macros.svh"

module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = lpht_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,    // initial_capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] key, [31] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] status, [2] found, [3] rehashed,
                                        // [4] grow_refused, [15:5] live_capacity,
                                        // [26:16] entry_count, [31:27] zero
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = CW + 4;
    localparam int KW = lpht_pkg::KEY_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_SCAN_RD   = 4'd2;
    localparam logic [3:0] S_SCAN_WR   = 4'd3;
    localparam logic [3:0] S_CLEAR     = 4'd4;
    localparam logic [3:0] S_RH_RD     = 4'd5;
    localparam logic [3:0] S_RH_KEY    = 4'd6;
    localparam logic [3:0] S_MOD_GO    = 4'd7;
    localparam logic [3:0] S_MOD       = 4'd8;
    localparam logic [3:0] S_PROBE_RD  = 4'd9;
    localparam logic [3:0] S_PROBE_CHK = 4'd10;
    localparam logic [3:0] S_FIN       = 4'd11;

    logic [31:0] slot_mem [TABLE_DEPTH];
    logic [KW-1:0] scr_mem [TABLE_DEPTH];

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_end, n_end;
    logic          r_ret_rh, n_ret_rh;
    logic          r_in_rh, n_in_rh;
    logic [CW-1:0] r_cap, n_cap;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_rhi, n_rhi;
    logic [lpht_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic [KW-1:0] r_key, n_key;
    logic [KW-1:0] r_pkey, n_pkey;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_start, n_start;
    logic [lpht_pkg::STATUS_W-1:0] r_status, n_status;
    logic          r_found, n_found;
    logic          r_rehashed, n_rehashed;
    logic          r_refused, n_refused;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_data, n_out_data;

    logic [31:0]   r_slot_rd;
    logic [KW-1:0] r_scr_rd;

    logic [AW-1:0] s_addr;
    logic          s_we;
    logic [31:0]   s_wdata;
    logic [AW-1:0] s_scr_addr;
    logic          s_scr_we;

    lpht_pkg::t_mod_req s_mod_req;
    logic          s_mod_done;
    logic [CW-1:0] s_mod_rem;

    logic [LW-1:0] s_lhs, s_rhs;
    logic          s_grow_ok;
    logic [CW-1:0] s_cfg_cap;
    logic [31:0]   s_cfg32;
    logic [CW-1:0] s_nxt;
    logic          s_wrap;
    logic          s_accept;

    lpht_mod #(.CW(CW)) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (s_mod_req),
        .i_divisor (r_cap),
        .o_done    (s_mod_done),
        .o_rem     (s_mod_rem)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign s_mod_req.start    = (r_state == S_MOD_GO);
    assign s_mod_req.dividend = r_pkey;

    assign s_lhs     = (LW'(r_count) + LW'(1)) * LW'(10);
    assign s_rhs     = LW'(r_cap) * LW'(7);
    assign s_grow_ok = ({1'b0, r_cap} << 1) <= (CW+1)'(TABLE_DEPTH);
    assign s_cfg32   = 32'(i_cfg_wdata);
    assign s_cfg_cap = (s_cfg32 == 32'd0) ? CW'(1) :
                       (s_cfg32 > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(s_cfg32);
    assign s_nxt     = ((CW'(r_idx) + CW'(1)) == r_cap) ? '0 : (CW'(r_idx) + CW'(1));
    assign s_wrap    = (s_nxt[AW-1:0] == r_start);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_ret_rh    = r_ret_rh;
        n_in_rh     = r_in_rh;
        n_cap       = r_cap;
        n_count     = r_count;
        n_n         = r_n;
        n_rhi       = r_rhi;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_pkey      = r_pkey;
        n_idx       = r_idx;
        n_start     = r_start;
        n_status    = r_status;
        n_found     = r_found;
        n_rehashed  = r_rehashed;
        n_refused   = r_refused;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        s_addr      = r_idx;
        s_we        = 1'b0;
        s_wdata     = '0;
        s_scr_addr  = r_rhi[AW-1:0];
        s_scr_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_cmd      = s_axis_tuser;
                    n_key      = s_axis_tdata[KW-1:0];
                    n_pkey     = s_axis_tdata[KW-1:0];
                    n_status   = lpht_pkg::STATUS_DONE;
                    n_found    = 1'b0;
                    n_rehashed = 1'b0;
                    n_refused  = 1'b0;
                    n_in_rh    = 1'b0;
                    case (s_axis_tuser)
                        lpht_pkg::CMD_INSERT: n_state = S_CHECK;
                        lpht_pkg::CMD_SEARCH,
                        lpht_pkg::CMD_REMOVE: n_state = S_MOD_GO;
                        default:              n_state = S_FIN;
                    endcase
                end
            end
            S_CHECK: begin
                if ((s_lhs > s_rhs) && s_grow_ok) begin
                    n_rehashed = 1'b1;
                    n_ptr      = '0;
                    n_n        = '0;
                    n_state    = S_SCAN_RD;
                end else begin
                    n_refused = (s_lhs > s_rhs);
                    n_state   = S_MOD_GO;
                end
            end
            S_SCAN_RD: begin
                s_addr  = r_ptr[AW-1:0];
                n_state = S_SCAN_WR;
            end
            S_SCAN_WR: begin
                s_scr_addr = r_n[AW-1:0];
                if (r_slot_rd[31]) begin
                    s_scr_we = 1'b1;
                    n_n      = r_n + CW'(1);
                end
                if ((r_ptr + CW'(1)) == r_cap) begin
                    n_ptr    = '0;
                    n_cap    = r_cap << 1;
                    n_end    = r_cap << 1;
                    n_count  = '0;
                    n_ret_rh = 1'b1;
                    n_state  = S_CLEAR;
                end else begin
                    n_ptr   = r_ptr + CW'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_CLEAR: begin
                s_addr = r_ptr[AW-1:0];
                s_we   = 1'b1;
                n_ptr  = r_ptr + CW'(1);
                if ((r_ptr + CW'(1)) == r_end) begin
                    n_rhi   = '0;
                    n_in_rh = r_ret_rh;
                    n_state = r_ret_rh ? S_RH_RD : S_IDLE;
                end
            end
            S_RH_RD: begin
                if (r_rhi == r_n) begin
                    n_in_rh = 1'b0;
                    n_pkey  = r_key;
                    n_state = S_MOD_GO;
                end else begin
                    n_state = S_RH_KEY;
                end
            end
            S_RH_KEY: begin
                n_pkey  = r_scr_rd;
                n_rhi   = r_rhi + CW'(1);
                n_state = S_MOD_GO;
            end
            S_MOD_GO: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (s_mod_done) begin
                    n_idx   = s_mod_rem[AW-1:0];
                    n_start = s_mod_rem[AW-1:0];
                    n_state = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (r_in_rh || (r_cmd == lpht_pkg::CMD_INSERT)) begin
                    if (!r_slot_rd[31]) begin
                        s_we    = 1'b1;
                        s_wdata = {1'b1, r_pkey};
                        n_count = r_count + CW'(1);
                        n_state = r_in_rh ? S_RH_RD : S_FIN;
                    end else if (s_wrap) begin
                        n_status = lpht_pkg::STATUS_FULL;
                        n_state  = S_FIN;
                    end else begin
                        n_idx   = s_nxt[AW-1:0];
                        n_state = S_PROBE_RD;
                    end
                end else if (r_slot_rd[31] && (r_slot_rd[KW-1:0] == r_pkey)) begin
                    if (r_cmd == lpht_pkg::CMD_SEARCH) begin
                        n_found = 1'b1;
                    end else begin
                        s_we    = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                    n_state = S_FIN;
                end else if (!r_slot_rd[31] || s_wrap) begin
                    if (r_cmd == lpht_pkg::CMD_REMOVE) begin
                        n_status = lpht_pkg::STATUS_ABSENT;
                    end
                    n_state = S_FIN;
                end else begin
                    n_idx   = s_nxt[AW-1:0];
                    n_state = S_PROBE_RD;
                end
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {5'b0, lpht_pkg::FIELD_W'(r_count),
                                   lpht_pkg::FIELD_W'(r_cap), r_refused, r_rehashed,
                                   r_found, r_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_cap    = s_cfg_cap;
            n_end    = s_cfg_cap;
            n_count  = '0;
            n_ptr    = '0;
            n_ret_rh = 1'b0;
            n_in_rh  = 1'b0;
            n_state  = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_end       <= CW'(lpht_pkg::RESET_CAP);
            r_cap       <= CW'(lpht_pkg::RESET_CAP);
            r_count     <= '0;
            r_ret_rh    <= 1'b0;
            r_in_rh     <= 1'b0;
            r_n         <= '0;
            r_rhi       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_end       <= n_end;
            r_cap       <= n_cap;
            r_count     <= n_count;
            r_ret_rh    <= n_ret_rh;
            r_in_rh     <= n_in_rh;
            r_n         <= n_n;
            r_rhi       <= n_rhi;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_key      <= n_key;
        r_pkey     <= n_pkey;
        r_idx      <= n_idx;
        r_start    <= n_start;
        r_status   <= n_status;
        r_found    <= n_found;
        r_rehashed <= n_rehashed;
        r_refused  <= n_refused;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            slot_mem[s_addr] <= s_wdata;
        end
        r_slot_rd <= slot_mem[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_scr_we) begin
            scr_mem[s_scr_addr] <= r_slot_rd[KW-1:0];
        end
        r_scr_rd <= scr_mem[s_scr_addr];
    end

    `ASSERT_ALWAYS(a_count_le_cap, i_clk, i_rst_n, r_count <= r_cap, "count above capacity")
    `ASSERT_ALWAYS(a_cap_range, i_clk, i_rst_n, (r_cap != '0) && (r_cap <= CW'(TABLE_DEPTH)), "capacity out of range")
    `ASSERT_ALWAYS(a_probe_in_cap, i_clk, i_rst_n, !(s_we && (r_state == S_PROBE_CHK)) || (CW'(r_idx) < r_cap), "probe write beyond capacity")
    `ASSERT_ALWAYS(a_mod_done_state, i_clk, i_rst_n, !s_mod_done || (r_state == S_MOD), "remainder done outside wait")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH      = lpht_pkg::DEPTH_DEF;
    localparam int IDLE_LIMIT = 50000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [lpht_pkg::STATUS_W-1:0] status;
        logic                found;
        logic                rehashed;
        logic                refused;
        logic [10:0]         capacity;
        logic [10:0]         count;
    } t_reply;

    typedef struct {
        logic [1:0]                    cmd;
        logic [lpht_pkg::KEY_W-1:0]    key;
        bit                            known;
        logic [lpht_pkg::STATUS_W-1:0] status;
        logic                          found;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    linear_probe_hash_table dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // table mirror
    bit                         slot_used [DEPTH];
    logic [lpht_pkg::KEY_W-1:0] slot_key  [DEPTH];
    logic [lpht_pkg::KEY_W-1:0] moved     [DEPTH];
    int unsigned      cap_now, key_count, cap_init;

    t_reply                     pending[$];
    logic [lpht_pkg::KEY_W-1:0] key_pool[$];
    int  errors = 0;
    int  hold_len = 0;
    bit  sender_done = 0;

    function automatic void clear_mirror();
        foreach (slot_used[i]) slot_used[i] = 0;
        key_count = 0;
        cap_now = (cap_init == 0) ? 1 : (cap_init > DEPTH) ? DEPTH : cap_init;
    endfunction

    function automatic bit place_key(logic [lpht_pkg::KEY_W-1:0] k);
        int unsigned home, idx;
        home = k % cap_now;
        idx = home;
        while (slot_used[idx]) begin
            idx = (idx + 1) % cap_now;
            if (idx == home) return 0;
        end
        slot_used[idx] = 1;
        slot_key[idx] = k;
        key_count++;
        return 1;
    endfunction

    function automatic int find_key(logic [lpht_pkg::KEY_W-1:0] k);
        int unsigned home, idx;
        home = k % cap_now;
        idx = home;
        forever begin
            if (!slot_used[idx]) return -1;
            if (slot_key[idx] == k) return idx;
            idx = (idx + 1) % cap_now;
            if (idx == home) return -1;
        end
    endfunction

    function automatic void grow_table();
        int unsigned n, old_cap;
        n = 0;
        old_cap = cap_now;
        for (int i = 0; i < old_cap; i++)
            if (slot_used[i]) begin
                moved[n] = slot_key[i];
                n++;
            end
        foreach (slot_used[i]) slot_used[i] = 0;
        key_count = 0;
        cap_now = old_cap * 2;
        for (int i = 0; i < n; i++) void'(place_key(moved[i]));
    endfunction

    function automatic t_reply apply_op(logic [1:0] cmd, logic [lpht_pkg::KEY_W-1:0] k);
        t_reply r;
        int at;
        r = '0;
        r.status = lpht_pkg::STATUS_DONE;
        case (cmd)
            lpht_pkg::CMD_INSERT: begin
                if (10 * (key_count + 1) > 7 * cap_now) begin
                    if (cap_now * 2 > DEPTH) r.refused = 1'b1;
                    else begin
                        grow_table();
                        r.rehashed = 1'b1;
                    end
                end
                if (!place_key(k)) r.status = lpht_pkg::STATUS_FULL;
            end
            lpht_pkg::CMD_SEARCH: r.found = (find_key(k) >= 0);
            lpht_pkg::CMD_REMOVE: begin
                at = find_key(k);
                if (at >= 0) begin
                    slot_used[at] = 0;
                    key_count--;
                end else begin
                    r.status = lpht_pkg::STATUS_ABSENT;
                end
            end
            default: ;
        endcase
        r.capacity = cap_now[10:0];
        r.count = key_count[10:0];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_reply got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[3], m_axis_tdata[4],
                    m_axis_tdata[15:5], m_axis_tdata[26:16]};
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected transfer %h", m_axis_tdata);
            end else begin
                want = pending.pop_front();
                if (got !== want || m_axis_tdata[31:27] !== 5'd0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp st=%0d f=%0d rh=%0d rf=%0d cap=%0d cnt=%0d",
                                  " | got st=%0d f=%0d rh=%0d rf=%0d cap=%0d cnt=%0d"},
                                 want.status, want.found, want.rehashed, want.refused,
                                 want.capacity, want.count, got.status, got.found,
                                 got.rehashed, got.refused, got.capacity, got.count);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        int r;
        if (hold_len > 0) begin
            m_axis_tready <= 1'b0;
            repeat (hold_len) @(negedge i_clk);
            hold_len = 0;
        end else begin
            r = $urandom_range(99);
            if (r < 60) m_axis_tready <= 1'b1;
            else if (r < 95) m_axis_tready <= 1'b0;
            else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(40, 10)) @(negedge i_clk);
            end
        end
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("[linear_probe_hash_table] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_op(logic [1:0] cmd, logic [lpht_pkg::KEY_W-1:0] k, bit known = 0,
                           logic [lpht_pkg::STATUS_W-1:0] st = lpht_pkg::STATUS_DONE,
                           logic fd = 1'b0);
        int gap;
        t_reply r;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, k};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        r = apply_op(cmd, k);
        if (known) begin
            r.status = st;
            r.found = fd;
        end
        pending.push_back(r);
        if (cmd == lpht_pkg::CMD_INSERT && key_pool.size() < 64) key_pool.push_back(k);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [10:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cap_init = v;
        clear_mirror();
        key_pool.delete();
    endtask

    function automatic logic [lpht_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 50 && key_pool.size() > 0) return key_pool[$urandom_range(key_pool.size() - 1)];
        if (r < 75) return lpht_pkg::KEY_W'($urandom_range(cap_now * 3));
        return lpht_pkg::KEY_W'($urandom());
    endfunction

    function automatic logic [1:0] pick_cmd(int insert_pct);
        int r;
        r = $urandom_range(99);
        if (r < insert_pct) return lpht_pkg::CMD_INSERT;
        if (r < insert_pct + (97 - insert_pct) / 2) return lpht_pkg::CMD_SEARCH;
        if (r < 97) return lpht_pkg::CMD_REMOVE;
        return CMD_UNUSED;
    endfunction

    t_row rows[] = '{
        '{lpht_pkg::CMD_SEARCH, 31'd0,         1, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_REMOVE, 31'd7,         1, lpht_pkg::STATUS_ABSENT, 1'b0},
        '{CMD_UNUSED,           31'h7FFF_FFFF, 1, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_INSERT, 31'd0,         1, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_INSERT, 31'h7FFF_FFFF, 1, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_INSERT, 31'd5,         0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_SEARCH, 31'd5,         1, lpht_pkg::STATUS_DONE,   1'b1},
        '{lpht_pkg::CMD_SEARCH, 31'h7FFF_FFFF, 1, lpht_pkg::STATUS_DONE,   1'b1},
        '{lpht_pkg::CMD_INSERT, 31'd10,        0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_INSERT, 31'd10,        0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_INSERT, 31'd20,        0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_SEARCH, 31'd10,        0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_REMOVE, 31'd10,        0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_SEARCH, 31'd10,        0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_REMOVE, 31'd0,         0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_SEARCH, 31'd20,        0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_REMOVE, 31'h5555_5555, 1, lpht_pkg::STATUS_ABSENT, 1'b0},
        '{lpht_pkg::CMD_INSERT, 31'h2AAA_AAAA, 0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_SEARCH, 31'h1234_5678, 1, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_INSERT, 31'd3,         0, lpht_pkg::STATUS_DONE,   1'b0},
        '{lpht_pkg::CMD_INSERT, 31'd13,        0, lpht_pkg::STATUS_DONE,   1'b0}
    };

    logic [10:0] cap_steps[] = '{11'd1, 11'd0, 11'd7, 11'd2047, 11'd3, 11'd20};

    initial begin
        cap_init = lpht_pkg::RESET_CAP;
        clear_mirror();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i])
            send_op(rows[i].cmd, rows[i].key, rows[i].known, rows[i].status, rows[i].found);

        foreach (cap_steps[c]) begin
            write_capacity(cap_steps[c]);
            repeat (20) send_op(pick_cmd(55), pick_key());
        end

        // fill past the refusal point until the table is full
        write_capacity(11'd513);
        hold_len = 300;
        for (int n = 0; n < 530; n++)
            send_op(pick_cmd(n < 520 ? 100 : 60), pick_key());

        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0 && pending.size() == 0)
            $display("[linear_probe_hash_table] OK");
        else
            $display("[linear_probe_hash_table] ERROR");
        $finish;
    end
endmodule
